[sv/odpm_pkg.sv]
// shared widths, codes, constants and types of the ordered dither palette mapper
package odpm_pkg;

	localparam int ACTION_W = 3;
	localparam int SAMPLE_W = 8;
	localparam int LINE_W   = 12;
	localparam int INDEX_W  = 10;
	localparam int DATA_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// item actions
	localparam logic [ACTION_W-1:0] ACT_PIXEL     = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WR_QUOT   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_WR_REM    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_WR_MATRIX = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_WR_MAP    = 3'd4;

	// dither modes, anything above mono passes red through
	localparam logic [1:0] MODE_COLOUR = 2'd0;
	localparam logic [1:0] MODE_MONO   = 2'd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DITHER_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_COLOUR_MAP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MAP_BITS = 2'd3;

	localparam int LUMA_W = 15;
	localparam int LUMA_R = 35;
	localparam int LUMA_G = 55;
	localparam int LUMA_B = 10;
	// divide by 100: multiply by ceil(2^19 / 100), exact for sums up to 25500
	localparam int LUMA_RECIP   = 5243;
	localparam int LUMA_RECIP_W = 13;
	localparam int LUMA_SHIFT   = 19;

	localparam int QUANT_W      = 9;
	localparam int GREEN_WEIGHT = 6;
	localparam int BLUE_WEIGHT  = 36;

	localparam int QTAB_DEPTH = 256;
	localparam int QTAB_AW    = 8;
	localparam int MAP_SECTIONS = 3;
	localparam logic [3:0] MAP_BITS_MAX = 4'd8;

	typedef struct packed {
		logic [1:0] dither_mode;
		logic [1:0] channel_count;
		logic       use_colour_map;
		logic [3:0] colour_map_bits;
	} cfg_t;

endpackage

[sv/odpm_if.sv]
// handshake channels of the ordered dither palette mapper
interface odpm_pix_if;
	logic valid;
	logic ready;
	logic [odpm_pkg::ACTION_W-1:0] action;
	logic [odpm_pkg::SAMPLE_W-1:0] red;
	logic [odpm_pkg::SAMPLE_W-1:0] green;
	logic [odpm_pkg::SAMPLE_W-1:0] blue;
	logic [odpm_pkg::LINE_W-1:0]   line;
	logic                          line_start;
	logic [odpm_pkg::INDEX_W-1:0]  table_index;
	logic [odpm_pkg::DATA_W-1:0]   table_value;

	modport source (
		output valid, action, red, green, blue, line, line_start, table_index, table_value,
		input  ready
	);
	modport sink (
		input  valid, action, red, green, blue, line, line_start, table_index, table_value,
		output ready
	);
endinterface

interface odpm_idx_if;
	logic valid;
	logic ready;
	logic [odpm_pkg::DATA_W-1:0] pixel_index;

	modport source (output valid, pixel_index, input ready);
	modport sink (input valid, pixel_index, output ready);
endinterface

interface odpm_cfg_if;
	logic valid;
	logic ready;
	logic [odpm_pkg::CFG_IDX_W-1:0]  index;
	logic [odpm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/ordered_dither_palette_mapper_top.sv]
// Ordered dither palette mapper: turns pixels into dithered 8-bit palette indexes.
// pixel_in carries items: pixels and table writes (quotient, remainder, threshold
// matrix, colour map). Table writes give no result; each pixel gives one index on
// index_out. cfg writes the four mode registers and is always ready; write it only
// while no item is in flight.
// One item is taken every clock unless a stall on index_out has filled every stage.
// The item runs through five pipeline stages and an output register. The depth
// comes from the registered table reads: colour map, threshold matrix, then
// quotient and remainder tables, with the luma divide by 100 done as a registered
// multiply in between.
// Reset clears the pipeline valids, the column phase and the registers (colour
// mode, three channels, no colour map, eight map bits); table contents are not
// reset and must be written before a pixel reads them.
// When index_out stalls, the output register holds its index and each stage holds
// until the one ahead of it empties; pixel_in.ready drops only once all are full.
module ordered_dither_palette_mapper_top #(
	parameter int MATRIX_SIZE = 16,
	parameter int MAP_ENTRIES = 768
) (
	input  logic        clk,
	input  logic        arst_n,
	odpm_cfg_if.sink    cfg,
	odpm_pix_if.sink    pixel_in,
	odpm_idx_if.source  index_out
);
	import odpm_pkg::*;

	localparam int PHASE_W   = $clog2(MATRIX_SIZE);
	localparam int MAT_DEPTH = MATRIX_SIZE * MATRIX_SIZE;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);
	localparam int MAP_AW    = $clog2(MAP_ENTRIES);
	// line mod MATRIX_SIZE through a reciprocal, exact for 12-bit lines
	localparam int ROW_SHIFT = 20;
	localparam int ROW_RECIP = (2 ** ROW_SHIFT + MATRIX_SIZE - 1) / MATRIX_SIZE;
	localparam int ROW_PROD_W = LINE_W + ROW_SHIFT;
	localparam int LUMA_PROD_W = LUMA_W + LUMA_RECIP_W;

	cfg_t cfg_c;

	odpm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_c)
	);

	// stage enables, each stage loads when it is empty or moves on
	logic en1, en2, en3, en4, en5, en_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic out_valid_q;
	logic [DATA_W-1:0] pixel_index_q;

	assign en_out = !out_valid_q || index_out.ready;
	assign en5    = !v_s5 || en_out;
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;

	assign pixel_in.ready        = en1;
	assign index_out.valid       = out_valid_q;
	assign index_out.pixel_index = pixel_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixel_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// ---------------- input transfer and column phase ----------------
	logic               in_xfer;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] col_in;

	assign in_xfer = pixel_in.valid && en1;
	assign col_in  = pixel_in.line_start ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_xfer && pixel_in.action == ACT_PIXEL) begin
			if (col_in == PHASE_W'(MATRIX_SIZE - 1)) begin
				phase_q <= '0;
			end else begin
				phase_q <= col_in + PHASE_W'(1);
			end
		end
	end

	// ---------------- stage 1: input register ----------------
	logic [ACTION_W-1:0] act_s1;
	logic [SAMPLE_W-1:0] smp_s1 [MAP_SECTIONS];
	logic [LINE_W-1:0]   line_s1;
	logic [PHASE_W-1:0]  col_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic [DATA_W-1:0]   val_s1;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_s1    <= pixel_in.action;
			smp_s1[0] <= pixel_in.red;
			// missing channels take red
			smp_s1[1] <= (cfg_c.channel_count < 2'd2) ? pixel_in.red : pixel_in.green;
			smp_s1[2] <= (cfg_c.channel_count < 2'd3) ? pixel_in.red : pixel_in.blue;
			line_s1   <= pixel_in.line;
			col_s1    <= col_in;
			idx_s1    <= pixel_in.table_index;
			val_s1    <= pixel_in.table_value;
		end
	end

	// ---------------- stage 2: colour map read, line quotient ----------------
	logic [3:0]          map_bits;
	logic [INDEX_W-1:0]  map_addr [MAP_SECTIONS];
	logic                map_we;
	logic [DATA_W-1:0]   map_rd [MAP_SECTIONS];
	logic [ROW_PROD_W-1:0] line_prod;

	assign map_bits  = (cfg_c.colour_map_bits > MAP_BITS_MAX) ? MAP_BITS_MAX
	                                                          : cfg_c.colour_map_bits;
	assign map_we    = en2 && v_s1 && act_s1 == ACT_WR_MAP
	                   && idx_s1 < INDEX_W'(MAP_ENTRIES);
	assign line_prod = ROW_PROD_W'(line_s1) * ROW_PROD_W'(ROW_RECIP);

	for (genvar c = 0; c < MAP_SECTIONS; c++) begin : g_map
		assign map_addr[c] = INDEX_W'(smp_s1[c]) + (INDEX_W'(c) << map_bits);

		odpm_ram #(
			.DEPTH (MAP_ENTRIES),
			.AW    (MAP_AW)
		) u_map (
			.clk   (clk),
			.we    (map_we),
			.waddr (idx_s1[MAP_AW-1:0]),
			.wdata (val_s1),
			.re    (en2),
			.raddr (map_addr[c][MAP_AW-1:0]),
			.rdata (map_rd[c])
		);
	end

	logic [ACTION_W-1:0] act_s2;
	logic [SAMPLE_W-1:0] smp_s2 [MAP_SECTIONS];
	logic [MAP_SECTIONS-1:0] map_ok_s2;
	logic [LINE_W-1:0]   line_s2;
	logic [LINE_W-1:0]   lineq_s2;
	logic [PHASE_W-1:0]  col_s2;
	logic [INDEX_W-1:0]  idx_s2;
	logic [DATA_W-1:0]   val_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			act_s2   <= act_s1;
			smp_s2   <= smp_s1;
			for (int c = 0; c < MAP_SECTIONS; c++) begin
				map_ok_s2[c] <= map_addr[c] < INDEX_W'(MAP_ENTRIES);
			end
			line_s2  <= line_s1;
			lineq_s2 <= line_prod[ROW_SHIFT +: LINE_W];
			col_s2   <= col_s1;
			idx_s2   <= idx_s1;
			val_s2   <= val_s1;
		end
	end

	// ---------------- stage 3: channel levels, luma sum, matrix row ----------------
	logic [SAMPLE_W-1:0] lvl [MAP_SECTIONS];
	logic [LUMA_W-1:0]   luma_sum;
	logic [LINE_W-1:0]   row_full;

	always_comb begin
		for (int c = 0; c < MAP_SECTIONS; c++) begin
			if (!cfg_c.use_colour_map) begin
				lvl[c] = smp_s2[c];
			end else if (map_ok_s2[c]) begin
				lvl[c] = map_rd[c];
			end else begin
				lvl[c] = '0;
			end
		end
	end

	assign luma_sum = LUMA_W'(lvl[0]) * LUMA_W'(LUMA_R)
	                + LUMA_W'(lvl[1]) * LUMA_W'(LUMA_G)
	                + LUMA_W'(lvl[2]) * LUMA_W'(LUMA_B);
	assign row_full = line_s2 - lineq_s2 * LINE_W'(MATRIX_SIZE);

	logic [ACTION_W-1:0] act_s3;
	logic [SAMPLE_W-1:0] red_s3;
	logic [SAMPLE_W-1:0] lvl_s3 [MAP_SECTIONS];
	logic [LUMA_W-1:0]   luma_s3;
	logic [PHASE_W-1:0]  row_s3;
	logic [PHASE_W-1:0]  col_s3;
	logic [INDEX_W-1:0]  idx_s3;
	logic [DATA_W-1:0]   val_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			act_s3  <= act_s2;
			red_s3  <= smp_s2[0];
			lvl_s3  <= lvl;
			luma_s3 <= luma_sum;
			row_s3  <= row_full[PHASE_W-1:0];
			col_s3  <= col_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
		end
	end

	// ---------------- stage 4: threshold read, luma divide ----------------
	logic [MAT_AW-1:0]      mat_raddr;
	logic                   mat_we;
	logic [DATA_W-1:0]      mat_rd;
	logic [LUMA_PROD_W-1:0] luma_prod;

	assign mat_raddr = MAT_AW'(row_s3) * MAT_AW'(MATRIX_SIZE) + MAT_AW'(col_s3);
	assign mat_we    = en4 && v_s3 && act_s3 == ACT_WR_MATRIX
	                   && idx_s3 < INDEX_W'(MAT_DEPTH);
	assign luma_prod = LUMA_PROD_W'(luma_s3) * LUMA_PROD_W'(LUMA_RECIP);

	odpm_ram #(
		.DEPTH (MAT_DEPTH),
		.AW    (MAT_AW)
	) u_matrix (
		.clk   (clk),
		.we    (mat_we),
		.waddr (idx_s3[MAT_AW-1:0]),
		.wdata (val_s3),
		.re    (en4),
		.raddr (mat_raddr),
		.rdata (mat_rd)
	);

	logic [ACTION_W-1:0] act_s4;
	logic [SAMPLE_W-1:0] red_s4;
	logic [SAMPLE_W-1:0] lvl_s4 [MAP_SECTIONS];
	logic [SAMPLE_W-1:0] luma_s4;
	logic [INDEX_W-1:0]  idx_s4;
	logic [DATA_W-1:0]   val_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			act_s4  <= act_s3;
			red_s4  <= red_s3;
			lvl_s4  <= lvl_s3;
			luma_s4 <= luma_prod[LUMA_SHIFT +: SAMPLE_W];
			idx_s4  <= idx_s3;
			val_s4  <= val_s3;
		end
	end

	// ---------------- stage 5: quotient and remainder reads ----------------
	logic [QTAB_AW-1:0] q_addr [MAP_SECTIONS];
	logic               quot_we;
	logic               rem_we;
	logic [DATA_W-1:0]  quot_rd [MAP_SECTIONS];
	logic [DATA_W-1:0]  rem_rd [MAP_SECTIONS];

	assign quot_we = en5 && v_s4 && act_s4 == ACT_WR_QUOT && idx_s4 < INDEX_W'(QTAB_DEPTH);
	assign rem_we  = en5 && v_s4 && act_s4 == ACT_WR_REM && idx_s4 < INDEX_W'(QTAB_DEPTH);

	for (genvar c = 0; c < MAP_SECTIONS; c++) begin : g_qtab
		// mono mode quantises the luma on the first copy
		if (c == 0) begin : g_first
			assign q_addr[c] = (cfg_c.dither_mode == MODE_MONO) ? luma_s4 : lvl_s4[c];
		end else begin : g_rest
			assign q_addr[c] = lvl_s4[c];
		end

		odpm_ram #(
			.DEPTH (QTAB_DEPTH),
			.AW    (QTAB_AW)
		) u_quot (
			.clk   (clk),
			.we    (quot_we),
			.waddr (idx_s4[QTAB_AW-1:0]),
			.wdata (val_s4),
			.re    (en5),
			.raddr (q_addr[c]),
			.rdata (quot_rd[c])
		);

		odpm_ram #(
			.DEPTH (QTAB_DEPTH),
			.AW    (QTAB_AW)
		) u_rem (
			.clk   (clk),
			.we    (rem_we),
			.waddr (idx_s4[QTAB_AW-1:0]),
			.wdata (val_s4),
			.re    (en5),
			.raddr (q_addr[c]),
			.rdata (rem_rd[c])
		);
	end

	logic [ACTION_W-1:0] act_s5;
	logic [SAMPLE_W-1:0] red_s5;
	logic [DATA_W-1:0]   thresh_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			act_s5    <= act_s4;
			red_s5    <= red_s4;
			thresh_s5 <= mat_rd;
		end
	end

	// ---------------- dither and output register ----------------
	logic [QUANT_W-1:0] dith [MAP_SECTIONS];
	logic [QUANT_W-1:0] cube_sum;
	logic [DATA_W-1:0]  result;

	always_comb begin
		for (int c = 0; c < MAP_SECTIONS; c++) begin
			dith[c] = QUANT_W'(quot_rd[c]) + QUANT_W'(rem_rd[c] > thresh_s5);
		end
	end

	assign cube_sum = dith[0] + dith[1] * QUANT_W'(GREEN_WEIGHT)
	                + dith[2] * QUANT_W'(BLUE_WEIGHT);

	always_comb begin
		case (cfg_c.dither_mode)
			MODE_COLOUR: result = cube_sum[DATA_W-1:0];
			MODE_MONO:   result = dith[0][DATA_W-1:0];
			default:     result = red_s5;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s5 && act_s5 == ACT_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			pixel_index_q <= result;
		end
	end

endmodule

[sv/odpm_ram.sv]
// single write port, single read port table memory with registered read data
module odpm_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [odpm_pkg::DATA_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [odpm_pkg::DATA_W-1:0] rdata
);
	import odpm_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read sees the old entry when the same address is written at that edge
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/odpm_cfg_regs.sv]
// configuration registers of the ordered dither palette mapper
module odpm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	odpm_cfg_if.sink      cfg,
	output odpm_pkg::cfg_t cfg_o
);
	import odpm_pkg::*;

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_o     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dither_mode     <= MODE_COLOUR;
			cfg_q.channel_count   <= 2'd3;
			cfg_q.use_colour_map  <= 1'b0;
			cfg_q.colour_map_bits <= MAP_BITS_MAX;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DITHER_MODE:     cfg_q.dither_mode     <= cfg.data[1:0];
				CFG_CHANNEL_COUNT:   cfg_q.channel_count   <= cfg.data[1:0];
				CFG_USE_COLOUR_MAP:  cfg_q.use_colour_map  <= cfg.data[0];
				CFG_COLOUR_MAP_BITS: cfg_q.colour_map_bits <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

[verif/odpm_index_checker.sv]
// checker for the ordered dither palette mapper: mirrors tables and registers, predicts indexes
module odpm_index_checker #(
	parameter int MATRIX_SIZE = 16,
	parameter int MAP_ENTRIES = 768
) (
	input  logic clk,
	input  logic arst_n,
	odpm_cfg_if  cfg,
	odpm_pix_if  pixel_in,
	odpm_idx_if  index_out,
	output int   mismatches,
	output int   pending
);
	import odpm_pkg::*;

	localparam int LUMA_DIVISOR = 100;
	localparam int REPORT_LIMIT = 10;

	cfg_t              regs;
	logic [DATA_W-1:0] quot_tab [QTAB_DEPTH];
	logic [DATA_W-1:0] rem_tab [QTAB_DEPTH];
	logic [DATA_W-1:0] thresh_tab [QTAB_DEPTH];
	logic [DATA_W-1:0] cmap [MAP_ENTRIES];
	logic [3:0]        column_phase;
	logic [DATA_W-1:0] expected_idx [$];

	// optional colour-map translation of one channel
	function automatic logic [7:0] map_level(input logic [7:0] v, input int section);
		int unsigned span;
		int unsigned addr;
		if (!regs.use_colour_map)
			return v;
		span = 1 << ((regs.colour_map_bits > MAP_BITS_MAX) ? 8 : regs.colour_map_bits);
		addr = v + section * span;
		return (addr < MAP_ENTRIES) ? cmap[addr] : 8'd0;
	endfunction

	function automatic logic [8:0] quantise_level(input logic [7:0] v, input logic [7:0] th);
		logic [8:0] q;
		q = {1'b0, quot_tab[v]};
		return (rem_tab[v] > th) ? q + 9'd1 : q;
	endfunction

	function automatic logic [7:0] dither_pixel(input logic [7:0] r, g, b, th);
		logic [7:0]  lr, lg, lb;
		logic [8:0]  mono_q;
		int unsigned luma, cube;
		lr = map_level(r, 0);
		lg = map_level(g, 1);
		lb = map_level(b, 2);
		case (regs.dither_mode)
			MODE_COLOUR: begin
				cube = quantise_level(lr, th) + GREEN_WEIGHT * quantise_level(lg, th)
					+ BLUE_WEIGHT * quantise_level(lb, th);
				return cube[7:0];
			end
			MODE_MONO: begin
				luma = (LUMA_R * lr + LUMA_G * lg + LUMA_B * lb) / LUMA_DIVISOR;
				mono_q = quantise_level(luma[7:0], th);
				return mono_q[7:0];
			end
			default: return r;
		endcase
	endfunction

	task automatic absorb_item();
		int         col, row;
		logic [7:0] r, g, b, th;
		case (pixel_in.action)
			ACT_WR_QUOT:
				if (pixel_in.table_index < QTAB_DEPTH)
					quot_tab[pixel_in.table_index[QTAB_AW-1:0]] = pixel_in.table_value;
			ACT_WR_REM:
				if (pixel_in.table_index < QTAB_DEPTH)
					rem_tab[pixel_in.table_index[QTAB_AW-1:0]] = pixel_in.table_value;
			ACT_WR_MATRIX:
				if (pixel_in.table_index < MATRIX_SIZE * MATRIX_SIZE)
					thresh_tab[pixel_in.table_index[QTAB_AW-1:0]] = pixel_in.table_value;
			ACT_WR_MAP:
				if (pixel_in.table_index < MAP_ENTRIES)
					cmap[pixel_in.table_index] = pixel_in.table_value;
			ACT_PIXEL: begin
				col = pixel_in.line_start ? 0 : column_phase;
				if (col >= MATRIX_SIZE)
					col = 0;
				row = pixel_in.line % MATRIX_SIZE;
				th = thresh_tab[(row * MATRIX_SIZE + col) % QTAB_DEPTH];
				column_phase = 4'((col + 1) % MATRIX_SIZE);
				r = pixel_in.red;
				g = (regs.channel_count < 2) ? r : pixel_in.green;
				b = (regs.channel_count < 3) ? r : pixel_in.blue;
				expected_idx.push_back(dither_pixel(r, g, b, th));
			end
			default: ;
		endcase
	endtask

	task automatic check_index(input logic [7:0] got);
		logic [7:0] want;
		if (expected_idx.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("pixel_index %0d arrived with no pixel pending", got);
		end else begin
			want = expected_idx.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("pixel_index mismatch: expected %0d, got %0d", want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.dither_mode = MODE_COLOUR;
			regs.channel_count = 2'd3;
			regs.use_colour_map = 1'b0;
			regs.colour_map_bits = MAP_BITS_MAX;
			column_phase = '0;
			expected_idx.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// retire first: a result can never belong to a pixel taken on the same edge
			if (index_out.valid && index_out.ready)
				check_index(index_out.pixel_index);
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DITHER_MODE:     regs.dither_mode = cfg.data[1:0];
					CFG_CHANNEL_COUNT:   regs.channel_count = cfg.data[1:0];
					CFG_USE_COLOUR_MAP:  regs.use_colour_map = cfg.data[0];
					CFG_COLOUR_MAP_BITS: regs.colour_map_bits = cfg.data;
					default: ;
				endcase
			end
			if (pixel_in.valid && pixel_in.ready)
				absorb_item();
			pending = expected_idx.size();
		end
	end

endmodule

[verif/tb_ordered_dither_palette_mapper_top.sv]
// testbench top for the ordered dither palette mapper: stimulus, flow control and verdict
module tb_ordered_dither_palette_mapper_top;
	import odpm_pkg::*;

	localparam int MATRIX_SIZE     = 16;
	localparam int MAP_ENTRIES     = 768;
	localparam int PIPE_DRAIN      = 8;
	localparam int RUN_LIMIT       = 5_000_000;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 100;

	localparam logic [1:0] MODE_PASS     = 2'd2;
	localparam logic [1:0] MODE_PASS_ALT = 2'd3;
	localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
		logic [LINE_W-1:0]   line;
		logic                line_start;
		logic [INDEX_W-1:0]  table_index;
		logic [DATA_W-1:0]   table_value;
	} pix_item_t;

	logic              clk;
	logic              arst_n;
	int                mismatches;
	int                pending;
	bit                src_gaps;
	bit                sink_stalls;
	int                ready_run;
	logic [LINE_W-1:0] cur_line;
	int                cols_left;

	odpm_cfg_if cfg_if();
	odpm_pix_if pix_if();
	odpm_idx_if idx_if();

	ordered_dither_palette_mapper_top #(
		.MATRIX_SIZE(MATRIX_SIZE),
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.pixel_in(pix_if),
		.index_out(idx_if)
	);

	odpm_index_checker #(
		.MATRIX_SIZE(MATRIX_SIZE),
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.pixel_in(pix_if),
		.index_out(idx_if),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pix_item_t pixel(input logic [7:0] r, g, b, input logic [LINE_W-1:0] ln,
			input logic start);
		pix_item_t it;
		it = '0;
		it.action = ACT_PIXEL;
		it.red = r;
		it.green = g;
		it.blue = b;
		it.line = ln;
		it.line_start = start;
		return it;
	endfunction

	function automatic pix_item_t table_write(input logic [ACTION_W-1:0] act,
			input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
		pix_item_t it;
		it = '0;
		it.action = act;
		it.table_index = idx;
		it.table_value = val;
		return it;
	endfunction

	// result side back-pressure, in runs
	always @(negedge clk) begin
		if (ready_run == 0) begin
			if (sink_stalls && $urandom_range(0, 2) == 0) begin
				idx_if.ready <= 1'b0;
				ready_run = 1 + pick_gap();
			end else begin
				idx_if.ready <= 1'b1;
				ready_run = $urandom_range(1, 24);
			end
		end
		ready_run = ready_run - 1;
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input pix_item_t it);
		int gap;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.action <= it.action;
		pix_if.red <= it.red;
		pix_if.green <= it.green;
		pix_if.blue <= it.blue;
		pix_if.line <= it.line;
		pix_if.line_start <= it.line_start;
		pix_if.table_index <= it.table_index;
		pix_if.table_value <= it.table_value;
		do @(posedge clk); while (!pix_if.ready);
		@(negedge clk);
	endtask

	// table writes leave no result behind, so give the pipeline time to empty
	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
	endtask

	// unused upper data bits carry junk
	task automatic program_regs(input logic [1:0] mode, input logic [1:0] count,
			input logic use_map, input logic [3:0] map_bits);
		logic [1:0] pad;
		pad = 2'($urandom_range(0, 3));
		write_reg(CFG_DITHER_MODE, {pad, mode});
		write_reg(CFG_CHANNEL_COUNT, {~pad, count});
		write_reg(CFG_USE_COLOUR_MAP, {pad, ~pad[0], use_map});
		write_reg(CFG_COLOUR_MAP_BITS, map_bits);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(input int n);
		pix_item_t it;
		int        counted, roll, limit;
		counted = 0;
		while (counted < n) begin
			roll = $urandom_range(0, 99);
			it.red = rand_sample();
			it.green = rand_sample();
			it.blue = rand_sample();
			it.line = LINE_W'($urandom);
			it.line_start = 1'($urandom);
			it.table_index = INDEX_W'($urandom);
			it.table_value = DATA_W'($urandom);
			if (roll < 72) begin
				// well-formed scanline runs
				it.action = ACT_PIXEL;
				if (cols_left == 0) begin
					cur_line = ($urandom_range(0, 7) == 0) ? LINE_W'($urandom) : cur_line + 1'b1;
					cols_left = $urandom_range(1, 40);
					it.line_start = 1'b1;
				end else begin
					it.line_start = 1'b0;
				end
				it.line = cur_line;
				cols_left--;
				counted++;
			end else if (roll < 80) begin
				it.action = ACT_PIXEL;
				counted++;
			end else if (roll < 95) begin
				it.action = ACTION_W'($urandom_range(ACT_WR_QUOT, ACT_WR_MAP));
				limit = (it.action == ACT_WR_MAP) ? MAP_ENTRIES : QTAB_DEPTH;
				if ($urandom_range(0, 9) != 0)
					it.table_index = INDEX_W'($urandom_range(0, limit - 1));
				if (it.table_index < limit)
					counted++;
			end else begin
				it.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			end
			send_item(it);
		end
	endtask

	initial begin
		pix_item_t  it;
		logic [1:0] mode, count;
		logic       use_map;
		logic [3:0] map_bits;

		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.action = ACT_PIXEL;
		pix_if.red = '0;
		pix_if.green = '0;
		pix_if.blue = '0;
		pix_if.line = '0;
		pix_if.line_start = 1'b0;
		pix_if.table_index = '0;
		pix_if.table_value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_DITHER_MODE;
		cfg_if.data = '0;
		idx_if.ready = 1'b0;
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		ready_run = 0;
		cur_line = '0;
		cols_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every table entry is written before any pixel can read it
		for (int v = 0; v < QTAB_DEPTH; v++) begin
			send_item(table_write(ACT_WR_QUOT, INDEX_W'(v), DATA_W'((v * 6) >> 8)));
			send_item(table_write(ACT_WR_REM, INDEX_W'(v), DATA_W'($urandom)));
			send_item(table_write(ACT_WR_MATRIX, INDEX_W'(v), DATA_W'($urandom)));
		end
		for (int a = 0; a < MAP_ENTRIES; a++)
			send_item(table_write(ACT_WR_MAP, INDEX_W'(a), DATA_W'($urandom)));
		wait_idle();
		program_regs(MODE_COLOUR, 2'd3, 1'b0, MAP_BITS_MAX);

		send_item(pixel(8'h00, 8'h00, 8'h00, 12'h000, 1'b1));
		send_item(pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 1'b1));
		send_item(pixel(8'hFF, 8'h00, 8'h80, 12'hFFF, 1'b0));
		send_item(pixel(8'h01, 8'hFE, 8'h7F, 12'h00F, 1'b0));
		// top level with zero threshold rounds up past 255 and the cube sum wraps
		send_item(table_write(ACT_WR_QUOT, 10'd255, 8'hFF));
		send_item(table_write(ACT_WR_REM, 10'd255, 8'hFF));
		send_item(table_write(ACT_WR_MATRIX, 10'd0, 8'h00));
		send_item(pixel(8'hFF, 8'hFF, 8'hFF, 12'h010, 1'b1));
		send_item(table_write(ACT_WR_MATRIX, 10'd255, 8'hFF));
		// writes past the end of each store are dropped; the map write to 767 hits its last entry
		send_item(table_write(ACT_WR_QUOT, 10'd256, 8'h07));
		send_item(table_write(ACT_WR_QUOT, 10'h3FF, 8'h07));
		send_item(table_write(ACT_WR_REM, 10'd767, 8'h09));
		send_item(table_write(ACT_WR_MATRIX, 10'd256, 8'h09));
		send_item(table_write(ACT_WR_MAP, 10'd767, 8'h00));
		send_item(table_write(ACT_WR_MAP, 10'd768, 8'h00));
		send_item(table_write(ACT_WR_MAP, 10'h3FF, 8'hFF));
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
			it = pixel(rand_sample(), rand_sample(), rand_sample(), LINE_W'($urandom), 1'b1);
			it.action = ACTION_W'(a);
			it.table_index = INDEX_W'($urandom);
			it.table_value = DATA_W'($urandom);
			send_item(it);
		end
		send_item(pixel(8'hC8, 8'h64, 8'h32, 12'hABF, 1'b0));
		send_item(pixel(8'hFF, 8'h00, 8'hFF, 12'hABF, 1'b0));
		send_item(pixel(8'h00, 8'hFF, 8'h00, 12'hABF, 1'b0));

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: program_regs(MODE_MONO, 2'd1, 1'b1, 4'd1);
				1: program_regs(MODE_PASS, 2'd2, 1'b1, 4'd15);
				2: program_regs(MODE_PASS_ALT, 2'd0, 1'b1, 4'd0);
				3: program_regs(MODE_COLOUR, 2'd3, 1'b1, MAP_BITS_MAX);
				4: program_regs(MODE_MONO, 2'd3, 1'b0, 4'd9);
				5: program_regs(MODE_COLOUR, 2'd1, 1'b0, 4'd1);
				default: begin
					mode = 2'($urandom_range(0, 3));
					count = 2'($urandom_range(0, 3));
					use_map = 1'($urandom_range(0, 1));
					map_bits = 4'($urandom_range(0, 15));
					program_regs(mode, count, use_map, map_bits);
				end
			endcase
			src_gaps = (p % 3) != 0;
			sink_stalls = (p % 4) != 1;
			run_phase(ITEMS_PER_PHASE);
		end

		wait_idle();
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
sv/odpm_pkg.sv
sv/odpm_if.sv
sv/odpm_ram.sv
sv/odpm_cfg_regs.sv
sv/ordered_dither_palette_mapper_top.sv
verif/odpm_index_checker.sv
verif/tb_ordered_dither_palette_mapper_top.sv
